@@ hdl/scma_pkg.sv @@
package scma_pkg;

   // Build-time sizing of the segment store.
   localparam int NUM_SEGMENTS  = 4;
   localparam int SEGMENT_BYTES = 4096;

   // Fixed register file and word layout.
   localparam int WINDOW_REGS = 4;
   localparam int NUM_BANKS   = 4;
   localparam int COUNT_W     = 3;
   localparam int FLAGS_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Derived sizes.
   localparam int SEARCH_SEGS  = (NUM_SEGMENTS < WINDOW_REGS) ? NUM_SEGMENTS : WINDOW_REGS;
   localparam int SEG_IDX_W    = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int ROWS_PER_SEG = (SEGMENT_BYTES + NUM_BANKS - 1) / NUM_BANKS;
   localparam int ROW_W        = $clog2(ROWS_PER_SEG);
   localparam int BANK_DEPTH   = NUM_SEGMENTS * ROWS_PER_SEG;
   localparam int BANK_ADDR_W  = $clog2(BANK_DEPTH);

   typedef enum logic [2:0] {
      OP_READ_BYTE   = 3'd0,
      OP_WRITE_BYTE  = 3'd1,
      OP_READ_WORD   = 3'd2,
      OP_WRITE_WORD  = 3'd3,
      OP_PRELOAD_WORD = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_SEGMENT   = 2'd1,
      STATUS_NO_CONTENT   = 2'd2,
      STATUS_NOT_WRITABLE = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEGMENT_COUNT = 3'd0,
      CSR_SEG0_WINDOW   = 3'd1,
      CSR_SEG1_WINDOW   = 3'd2,
      CSR_SEG2_WINDOW   = 3'd3,
      CSR_SEG3_WINDOW   = 3'd4,
      CSR_SEGMENT_FLAGS = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_ADDR,
      ST_MEM,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic lookup;
      logic addr_calc;
      logic mem_access;
      logic finish;
      logic clear;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic out_busy;
   } dp_status_type;

endpackage

@@ hdl/segment_checked_memory_access.sv @@
// Segment-checked memory access unit.
// Request channel (req_): opcode, address and write data; a transaction is
// taken at a clock edge where req_valid is high and req_stall is low.
// Response channel (rsp_): status and read data, one response per request,
// in order, under the same valid/stall rule.
// Configuration (csr_): a write of csr_data to register csr_index whenever
// csr_write is high; do this only while no request is in flight.
// Sequence: once taken, a request passes through the segment search, the bank
// address, the bank access and the result register, each registered in turn.
// The controller handles one request at a time through that sequence and
// takes no new request until the last one is written into the result register.
// Reset: a synchronous clear of the configuration, control and response
// valid registers, then a sweep that zeroes the four byte banks one row per
// cycle over 4096 rows per bank at the default sizing
// (NUM_SEGMENTS * SEGMENT_BYTES / 4). req_stall stays high during the sweep;
// configuration writes are taken as usual.
// Receiver stall: the result register holds the response; a new request is
// still taken, and it waits in its last step until the register frees up.
module segment_checked_memory_access
   import scma_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_opcode,
   input  logic [31:0]            req_address,
   input  logic [31:0]            req_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_read_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   // Sequencer.
   scma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .dp_status (dp_status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Segment search, byte banks and result register.
   scma_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dp_status      (dp_status),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

endmodule

@@ hdl/scma_ctrl.sv @@
module scma_ctrl
   import scma_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type dp_status,
   output logic          req_stall,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (dp_status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_MEM;
         ST_MEM:    state_in = ST_DONE;
         ST_DONE: begin
            if (!dp_status.out_busy) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Commands for the datapath.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOOKUP: cmd.lookup     = 1'b1;
         ST_ADDR:   cmd.addr_calc  = 1'b1;
         ST_MEM:    cmd.mem_access = 1'b1;
         ST_DONE:   cmd.finish     = !dp_status.out_busy;
         default:   cmd            = '0;
      endcase
   end

endmodule

@@ hdl/scma_datapath.sv @@
module scma_datapath
   import scma_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          dp_status,
   input  logic [2:0]             req_opcode,
   input  logic [31:0]            req_address,
   input  logic [31:0]            req_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_read_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   logic [COUNT_W-1:0]    segment_count_ff;
   logic [CSR_DATA_W-1:0] window_ff [WINDOW_REGS];
   logic [FLAGS_W-1:0]    flags_ff;

   // Captured transaction.
   logic [2:0]  op_ff;
   logic [31:0] addr_ff;
   logic [31:0] wdata_ff;

   // Lookup results.
   logic                 known_ff;
   logic [SEG_IDX_W-1:0] seg_ff;
   logic [31:0]          start_ff;
   status_type           status_ff;
   status_type           status_in;

   // Per-bank access controls.
   logic [BANK_ADDR_W-1:0] bank_addr_ff  [NUM_BANKS];
   logic [BANK_ADDR_W-1:0] bank_addr_in  [NUM_BANKS];
   logic [7:0]             bank_wdata_ff [NUM_BANKS];
   logic [7:0]             bank_wdata_in [NUM_BANKS];
   logic [1:0]             bank_lane_ff  [NUM_BANKS];
   logic [1:0]             bank_lane_in  [NUM_BANKS];
   logic [NUM_BANKS-1:0]   bank_we_ff;
   logic [NUM_BANKS-1:0]   bank_we_in;
   logic [NUM_BANKS-1:0]   bank_rd_ff;
   logic [NUM_BANKS-1:0]   bank_rd_in;
   logic [7:0]             bank_rdata_ff [NUM_BANKS];

   // Byte banks and the clearing sweep.
   logic [7:0]             bank_mem [NUM_BANKS][BANK_DEPTH];
   logic [BANK_ADDR_W-1:0] clear_row_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_read_data_ff;

   // Lookup working signals.
   logic                 known;
   logic                 word_op;
   logic [COUNT_W-1:0]   active;
   logic [32:0]          lo;
   logic [32:0]          hi;
   logic [32:0]          seg_start;
   logic [32:0]          seg_end;
   logic                 hit;
   logic [SEG_IDX_W-1:0] hit_seg;
   logic [31:0]          hit_start;
   logic                 hit_content;
   logic                 hit_rw;

   // Address working signals.
   logic        go;
   logic        stores;
   logic        loads;
   logic [31:0] offset;
   logic [1:0]  lane;
   logic [32:0] byte_off;
   logic        need;
   logic        in_store;
   logic [ROW_W-1:0] row;

   // Read assembly.
   logic [7:0]  lanes [NUM_BANKS];
   logic [31:0] read_value;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         segment_count_ff <= '0;
         flags_ff         <= '0;
         for (int w = 0; w < WINDOW_REGS; w++) begin
            window_ff[w] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_data[COUNT_W-1:0];
            CSR_SEG0_WINDOW:   window_ff[0]     <= csr_data;
            CSR_SEG1_WINDOW:   window_ff[1]     <= csr_data;
            CSR_SEG2_WINDOW:   window_ff[2]     <= csr_data;
            CSR_SEG3_WINDOW:   window_ff[3]     <= csr_data;
            CSR_SEGMENT_FLAGS: flags_ff         <= csr_data[FLAGS_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture an accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
   end

   assign known = (op_ff == OP_READ_BYTE) || (op_ff == OP_WRITE_BYTE) ||
                  (op_ff == OP_READ_WORD) || (op_ff == OP_WRITE_WORD) ||
                  (op_ff == OP_PRELOAD_WORD);
   assign word_op = (op_ff == OP_READ_WORD) || (op_ff == OP_WRITE_WORD) ||
                    (op_ff == OP_PRELOAD_WORD);
   assign active = (segment_count_ff > COUNT_W'(SEARCH_SEGS)) ?
                   COUNT_W'(SEARCH_SEGS) : segment_count_ff;

   // Segment search at 33 bits; the lowest matching segment wins.
   always_comb begin
      lo          = {1'b0, addr_ff};
      hi          = lo + (word_op ? 33'd4 : 33'd1);
      seg_start   = '0;
      seg_end     = '0;
      hit         = 1'b0;
      hit_seg     = '0;
      hit_start   = '0;
      hit_content = 1'b0;
      hit_rw      = 1'b0;
      for (int i = SEARCH_SEGS - 1; i >= 0; i--) begin
         seg_start = {1'b0, window_ff[i][63:32]};
         seg_end   = seg_start + {1'b0, window_ff[i][31:0]};
         if ((COUNT_W'(i) < active) && (lo >= seg_start) && (hi <= seg_end)) begin
            hit         = 1'b1;
            hit_seg     = SEG_IDX_W'(i);
            hit_start   = window_ff[i][63:32];
            hit_content = flags_ff[2*i];
            hit_rw      = flags_ff[2*i+1];
         end
      end
   end

   // Status of the access; an unknown opcode reports ok and does nothing.
   always_comb begin
      status_in = STATUS_OK;
      if (known) begin
         if (!hit) begin
            status_in = STATUS_NO_SEGMENT;
         end else if ((op_ff != OP_PRELOAD_WORD) && !hit_content) begin
            status_in = STATUS_NO_CONTENT;
         end else if (((op_ff == OP_WRITE_BYTE) || (op_ff == OP_WRITE_WORD)) && !hit_rw) begin
            status_in = STATUS_NOT_WRITABLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         known_ff  <= known;
         seg_ff    <= hit_seg;
         start_ff  <= hit_start;
         status_ff <= status_in;
      end
   end

   assign go     = known_ff && (status_ff == STATUS_OK);
   assign stores = (op_ff == OP_WRITE_BYTE) || (op_ff == OP_WRITE_WORD) ||
                   (op_ff == OP_PRELOAD_WORD);
   assign loads  = (op_ff == OP_READ_BYTE) || (op_ff == OP_READ_WORD);
   assign offset = addr_ff - start_ff;

   // Spread the access over the byte banks; bytes past the store are dropped.
   always_comb begin
      lane     = '0;
      byte_off = '0;
      need     = 1'b0;
      in_store = 1'b0;
      row      = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         lane     = 2'(b) - offset[1:0];
         byte_off = {1'b0, offset} + {31'd0, lane};
         need     = word_op || (lane == 2'd0);
         in_store = byte_off < 33'(SEGMENT_BYTES);
         row      = byte_off[ROW_W+1:2];
         bank_lane_in[b]  = lane;
         bank_addr_in[b]  = BANK_ADDR_W'(seg_ff) * BANK_ADDR_W'(ROWS_PER_SEG) +
                            BANK_ADDR_W'(row);
         bank_wdata_in[b] = word_op ? wdata_ff[{~lane, 3'b000} +: 8] : wdata_ff[7:0];
         bank_we_in[b]    = go && stores && need && in_store;
         bank_rd_in[b]    = go && loads && need && in_store;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.addr_calc) begin
         bank_addr_ff  <= bank_addr_in;
         bank_wdata_ff <= bank_wdata_in;
         bank_lane_ff  <= bank_lane_in;
         bank_we_ff    <= bank_we_in;
         bank_rd_ff    <= bank_rd_in;
      end
   end

   // Clearing sweep row counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_row_ff <= '0;
      end else if (cmd.clear) begin
         clear_row_ff <= clear_row_ff + 1'b1;
      end
   end

   assign dp_status.clear_done = (clear_row_ff == BANK_ADDR_W'(BANK_DEPTH - 1));

   // Byte banks: one write and one registered read per bank per cycle.
   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (cmd.clear) begin
            bank_mem[b][clear_row_ff] <= 8'd0;
         end else if (cmd.mem_access) begin
            if (bank_we_ff[b]) begin
               bank_mem[b][bank_addr_ff[b]] <= bank_wdata_ff[b];
            end
            bank_rdata_ff[b] <= bank_mem[b][bank_addr_ff[b]];
         end
      end
   end

   // Put each bank's byte into its place in the big-endian word.
   always_comb begin
      for (int k = 0; k < NUM_BANKS; k++) begin
         lanes[k] = 8'd0;
      end
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (bank_rd_ff[b]) begin
            lanes[bank_lane_ff[b]] = bank_rdata_ff[b];
         end
      end
      read_value = (op_ff == OP_READ_WORD) ? {lanes[0], lanes[1], lanes[2], lanes[3]} :
                                             {24'd0, lanes[0]};
   end

   // Result register; it is free again once its transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff    <= status_ff;
         rsp_read_data_ff <= read_value;
      end
   end

   assign dp_status.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_data      = rsp_read_data_ff;

endmodule

@@ tb/testbench.sv @@
module testbench;
   import scma_pkg::*;

   // Opcodes outside the defined set, used to check that they change nothing.
   localparam logic [2:0] OP_UNDEF_LO = 3'd5;
   localparam logic [2:0] OP_UNDEF_HI = 3'd7;

   localparam int STORE_SIZE     = NUM_SEGMENTS * SEGMENT_BYTES;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 154;
   localparam int SETTLE_CYCLES  = 6;
   localparam int DRAIN_CYCLES   = 12;
   localparam int HOLD_OFF       = 300;
   localparam int WATCHDOG_LIMIT = 25000;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_data;
   } access_result_t;

   // One line of the directed plan: either a register write or a transaction.
   typedef struct {
      bit             is_csr;
      csr_reg_type    reg_sel;
      logic [63:0]    reg_value;
      logic [2:0]     op;
      logic [31:0]    addr;
      logic [31:0]    wdata;
      bit             typed;
      access_result_t result;
   } plan_row_t;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [2:0]             req_opcode     = '0;
   logic [31:0]            req_address    = '0;
   logic [31:0]            req_write_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [1:0]             rsp_status;
   logic [31:0]            rsp_read_data;
   logic                   csr_write      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   // Shadow copy of the configuration and the byte store.
   logic [COUNT_W-1:0] cfg_count;
   logic [63:0]        cfg_window [WINDOW_REGS];
   logic [FLAGS_W-1:0] cfg_flags;
   logic [7:0]         shadow_bytes [STORE_SIZE];

   access_result_t pending_results [$];
   int             failures     = 0;
   int             idle_cycles  = 0;
   bit             tx_steady    = 1'b0;
   bit             rx_steady    = 1'b0;
   int unsigned    rx_hold_cycles = 0;

   segment_checked_memory_access u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Byte store accessors; offsets past the backing store read zero and drop writes.
   function automatic logic [7:0] peek_byte(int seg, logic [32:0] off);
      if (off >= SEGMENT_BYTES) return 8'h00;
      return shadow_bytes[seg * SEGMENT_BYTES + int'(off)];
   endfunction

   function automatic void poke_byte(int seg, logic [32:0] off, logic [7:0] value);
      if (off < SEGMENT_BYTES) shadow_bytes[seg * SEGMENT_BYTES + int'(off)] = value;
   endfunction

   // Computes the response of one transaction and applies its store update.
   function automatic access_result_t predict_access(logic [2:0] op, logic [31:0] addr,
                                                     logic [31:0] wd);
      access_result_t res;
      int             active;
      int             hit;
      bit             is_word;
      bit             is_write;
      logic [32:0]    first_byte;
      logic [32:0]    past_end;
      logic [32:0]    win_lo;
      logic [32:0]    win_hi;
      logic [32:0]    off;
      res.status = STATUS_OK;
      res.read_data = '0;
      if (op > OP_PRELOAD_WORD) return res;
      active = (cfg_count > SEARCH_SEGS) ? SEARCH_SEGS : int'(cfg_count);
      is_word = (op == OP_READ_WORD) || (op == OP_WRITE_WORD) || (op == OP_PRELOAD_WORD);
      is_write = (op == OP_WRITE_BYTE) || (op == OP_WRITE_WORD);
      first_byte = {1'b0, addr};
      past_end = first_byte + (is_word ? 33'd4 : 33'd1);
      hit = -1;
      // The bounds are compared at 33 bits so that a window never wraps.
      for (int i = 0; i < SEARCH_SEGS; i++) begin
         win_lo = {1'b0, cfg_window[i][63:32]};
         win_hi = win_lo + {1'b0, cfg_window[i][31:0]};
         if (hit < 0 && i < active && first_byte >= win_lo && past_end <= win_hi) hit = i;
      end
      if (hit < 0) begin
         res.status = STATUS_NO_SEGMENT;
         return res;
      end
      off = first_byte - {1'b0, cfg_window[hit][63:32]};
      if (op != OP_PRELOAD_WORD && !cfg_flags[2 * hit]) begin
         res.status = STATUS_NO_CONTENT;
      end else if (is_write && !cfg_flags[2 * hit + 1]) begin
         res.status = STATUS_NOT_WRITABLE;
      end else begin
         case (op)
            OP_READ_BYTE: begin
               res.read_data = {24'h0, peek_byte(hit, off)};
            end
            OP_WRITE_BYTE: begin
               poke_byte(hit, off, wd[7:0]);
            end
            OP_READ_WORD: begin
               res.read_data = {peek_byte(hit, off), peek_byte(hit, off + 1),
                                peek_byte(hit, off + 2), peek_byte(hit, off + 3)};
            end
            default: begin
               poke_byte(hit, off, wd[31:24]);
               poke_byte(hit, off + 1, wd[23:16]);
               poke_byte(hit, off + 2, wd[15:8]);
               poke_byte(hit, off + 3, wd[7:0]);
            end
         endcase
      end
      return res;
   endfunction

   function automatic plan_row_t csr_row(csr_reg_type sel, logic [63:0] value);
      plan_row_t row;
      row.is_csr = 1'b1;
      row.reg_sel = sel;
      row.reg_value = value;
      row.op = OP_READ_BYTE;
      row.addr = '0;
      row.wdata = '0;
      row.typed = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic plan_row_t run_row(logic [2:0] op, logic [31:0] addr, logic [31:0] wd);
      plan_row_t row;
      row.is_csr = 1'b0;
      row.reg_sel = CSR_SEGMENT_COUNT;
      row.reg_value = '0;
      row.op = op;
      row.addr = addr;
      row.wdata = wd;
      row.typed = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic plan_row_t chk_row(logic [2:0] op, logic [31:0] addr, logic [31:0] wd,
                                         status_type st, logic [31:0] rd);
      plan_row_t row;
      row = run_row(op, addr, wd);
      row.typed = 1'b1;
      row.result.status = st;
      row.result.read_data = rd;
      return row;
   endfunction

   // Random window: low, near the top of the address space, anywhere, or
   // overlapping the previous segment; sizes include zero and the maximum.
   function automatic logic [63:0] random_window(logic [31:0] prior_start);
      logic [31:0] start;
      logic [31:0] size;
      case ($urandom_range(0, 3))
         0: start = $urandom_range(0, 255) << 12;
         1: start = 32'hFFFF_FFFF - $urandom_range(0, 32'h3000);
         2: start = $urandom();
         default: start = prior_start + $urandom_range(0, 64);
      endcase
      case ($urandom_range(0, 7))
         0: size = 32'h0;
         1: size = 32'hFFFF_FFFF;
         2: size = $urandom();
         3: size = $urandom_range(1, 64);
         default: size = $urandom_range(64, 5000);
      endcase
      return {start, size};
   endfunction

   // Register write; csr_write then drops so that it is low between writes.
   task automatic write_reg(csr_reg_type sel, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      case (sel)
         CSR_SEGMENT_COUNT: cfg_count = value[COUNT_W-1:0];
         CSR_SEGMENT_FLAGS: cfg_flags = value[FLAGS_W-1:0];
         default: cfg_window[int'(sel) - int'(CSR_SEG0_WINDOW)] = value;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Stops offering and waits until every outstanding transaction has answered.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Offers one transaction after a random gap and records its expected response.
   task automatic send_access(logic [2:0] op, logic [31:0] addr, logic [31:0] wd,
                              bit typed, access_result_t typed_result);
      int unsigned    gap;
      access_result_t predicted;
      gap = tx_steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_address    <= addr;
      req_write_data <= wd;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_access(op, addr, wd);
      pending_results.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   // One random phase: a fresh configuration, then mostly accesses aimed at the
   // configured windows, with read-back of recent writes and some noise.
   task automatic run_random_phase(int phase);
      logic [2:0]  count;
      logic [7:0]  flags;
      logic [31:0] prior;
      logic [31:0] base;
      logic [31:0] span;
      logic [31:0] addr;
      logic [31:0] last_written;
      logic [2:0]  op;
      int unsigned pick;
      int unsigned seg;
      bit          have_written;
      have_written = 1'b0;
      last_written = '0;
      quiesce();
      tx_steady = (phase % 4 == 1);
      rx_steady = tx_steady;
      if (phase == 2) count = 3'd0;
      else if (phase % 4 == 0) count = 3'd7;
      else if (phase == 7) count = 3'd5;
      else count = $urandom_range(1, 4);
      write_reg(CSR_SEGMENT_COUNT, {61'h0, count});
      for (int s = 0; s < WINDOW_REGS; s++) begin
         prior = (s == 0) ? 32'h1000 : cfg_window[s - 1][63:32];
         write_reg(csr_reg_type'(int'(CSR_SEG0_WINDOW) + s), random_window(prior));
      end
      flags = $urandom_range(0, 255);
      if ($urandom_range(0, 1)) flags = flags | 8'h55;
      write_reg(CSR_SEGMENT_FLAGS, {56'h0, flags});

      // Let the response side back up while requests keep coming.
      if (phase == 3) begin
         tx_steady = 1'b1;
         rx_hold_cycles = HOLD_OFF;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (phase == 6 && n == PHASE_ITEMS / 2) quiesce();
         pick = $urandom_range(0, 99);
         if (pick < 3) op = $urandom_range(OP_UNDEF_LO, OP_UNDEF_HI);
         else op = $urandom_range(OP_READ_BYTE, OP_PRELOAD_WORD);
         seg = $urandom_range(0, WINDOW_REGS - 1);
         base = cfg_window[seg][63:32];
         span = cfg_window[seg][31:0];
         if (span > 32'd4300) span = 32'd4300;
         pick = $urandom_range(0, 99);
         if (pick < 12) addr = $urandom();
         else if (pick < 35 && have_written) addr = last_written;
         else if (pick < 70) addr = base + $urandom_range(0, 63);
         else addr = base + $urandom_range(0, span + 4) - 2;
         if (op == OP_WRITE_BYTE || op == OP_WRITE_WORD || op == OP_PRELOAD_WORD) begin
            have_written = 1'b1;
            last_written = addr;
         end
         send_access(op, addr, $urandom(), 1'b0, '0);
      end
   endtask

   // Response side: a random stall before each transaction, or one long hold-off.
   initial begin : response_sink
      int unsigned hold;
      @(negedge clock);
      forever begin
         if (rx_hold_cycles != 0) begin
            hold = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            hold = rx_steady ? 0 : $urandom_range(0, 9);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         @(negedge clock);
      end
   end

   // Compares each accepted response with the oldest expectation.
   always @(posedge clock) begin : check_responses
      access_result_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d, read_data 0x%08h",
                   rsp_status, rsp_read_data);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data mismatch: expected 0x%08h, actual 0x%08h",
                      want.read_data, rsp_read_data);
               failures++;
            end
         end
      end
   end

   // Ends the run when no transaction and no register write is seen for too long.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      plan_row_t plan [$];
      plan_row_t row;
      cfg_count = '0;
      cfg_flags = '0;
      for (int s = 0; s < WINDOW_REGS; s++) cfg_window[s] = '0;
      for (int i = 0; i < STORE_SIZE; i++) shadow_bytes[i] = 8'h00;

      // Directed plan. With the reset configuration nothing matches.
      plan.push_back(chk_row(OP_READ_BYTE, 32'h0, 32'h0, STATUS_NO_SEGMENT, 32'h0));
      // Read-write window, read-only window at the top of the address space,
      // zero-size window, and a window larger than its backing store.
      plan.push_back(csr_row(CSR_SEG0_WINDOW, {32'h0000_1000, 32'h0000_0100}));
      plan.push_back(csr_row(CSR_SEG1_WINDOW, {32'hFFFF_FFF0, 32'h0000_0010}));
      plan.push_back(csr_row(CSR_SEG2_WINDOW, {32'h0000_2000, 32'h0000_0000}));
      plan.push_back(csr_row(CSR_SEG3_WINDOW, {32'h0000_3000, 32'h0001_0000}));
      plan.push_back(csr_row(CSR_SEGMENT_FLAGS, 64'hC7));
      plan.push_back(csr_row(CSR_SEGMENT_COUNT, 64'h7));
      plan.push_back(chk_row(OP_READ_WORD, 32'h1000, 32'h0, STATUS_OK, 32'h0));
      plan.push_back(chk_row(OP_WRITE_WORD, 32'h1000, 32'hDEAD_BEEF, STATUS_OK, 32'h0));
      plan.push_back(run_row(OP_READ_WORD, 32'h1000, 32'h0));
      plan.push_back(run_row(OP_READ_BYTE, 32'h1001, 32'h0));
      plan.push_back(run_row(OP_WRITE_BYTE, 32'h1003, 32'hFFFF_FF5A));
      plan.push_back(run_row(OP_READ_WORD, 32'h1001, 32'h0));
      // A word that runs one byte past the end of its window.
      plan.push_back(chk_row(OP_READ_WORD, 32'h10FD, 32'h0, STATUS_NO_SEGMENT, 32'h0));
      plan.push_back(chk_row(OP_WRITE_WORD, 32'hFFFF_FFFC, 32'h0123_4567,
                             STATUS_NOT_WRITABLE, 32'h0));
      // This word would wrap past 2^32.
      plan.push_back(chk_row(OP_READ_WORD, 32'hFFFF_FFFD, 32'h0, STATUS_NO_SEGMENT, 32'h0));
      plan.push_back(chk_row(OP_PRELOAD_WORD, 32'h2000, 32'h1111_2222,
                             STATUS_NO_SEGMENT, 32'h0));
      // Writes at and across the end of the backing store.
      plan.push_back(chk_row(OP_WRITE_BYTE, 32'h3FFF, 32'h77, STATUS_OK, 32'h0));
      plan.push_back(chk_row(OP_WRITE_WORD, 32'h3FFE, 32'hA1B2_C3D4, STATUS_OK, 32'h0));
      plan.push_back(run_row(OP_READ_WORD, 32'h3FFE, 32'h0));
      plan.push_back(chk_row(OP_UNDEF_LO, 32'h1000, 32'hFFFF_FFFF, STATUS_OK, 32'h0));
      plan.push_back(chk_row(OP_UNDEF_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STATUS_OK, 32'h0));
      // No content anywhere; preload still goes through.
      plan.push_back(csr_row(CSR_SEGMENT_FLAGS, 64'h00));
      plan.push_back(csr_row(CSR_SEGMENT_COUNT, 64'h2));
      plan.push_back(chk_row(OP_READ_BYTE, 32'h1000, 32'h0, STATUS_NO_CONTENT, 32'h0));
      plan.push_back(chk_row(OP_WRITE_WORD, 32'h1000, 32'h5555_AAAA,
                             STATUS_NO_CONTENT, 32'h0));
      plan.push_back(chk_row(OP_PRELOAD_WORD, 32'h1004, 32'hCAFE_F00D, STATUS_OK, 32'h0));
      plan.push_back(chk_row(OP_READ_BYTE, 32'h3000, 32'h0, STATUS_NO_SEGMENT, 32'h0));
      // Extreme windows and every right granted.
      plan.push_back(csr_row(CSR_SEG0_WINDOW, {32'h0000_0000, 32'hFFFF_FFFF}));
      plan.push_back(csr_row(CSR_SEG2_WINDOW, 64'hFFFF_FFFF_FFFF_FFFF));
      plan.push_back(csr_row(CSR_SEG3_WINDOW, 64'h0));
      plan.push_back(csr_row(CSR_SEGMENT_FLAGS, 64'hFF));
      plan.push_back(csr_row(CSR_SEGMENT_COUNT, 64'h4));
      plan.push_back(run_row(OP_READ_WORD, 32'hFFFF_FFFC, 32'h0));
      plan.push_back(run_row(OP_WRITE_WORD, 32'h0, 32'hFFFF_FFFF));
      plan.push_back(run_row(OP_READ_BYTE, 32'h3, 32'h0));
      plan.push_back(run_row(OP_READ_WORD, 32'h4, 32'h0));
      plan.push_back(run_row(OP_READ_BYTE, 32'hFFFF_FFFF, 32'h0));

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr) begin
            quiesce();
            write_reg(row.reg_sel, row.reg_value);
         end else begin
            send_access(row.op, row.addr, row.wdata, row.typed, row.result);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);

      // Drain and finish.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
